FILE: src/bccni_pkg.sv
// Shared types and constants for the BCC lattice neighbour index block.
`default_nettype none

package bccni_pkg;

	// Fixed field widths
	localparam int IDX_W   = 26;
	localparam int DIR_W   = 4;
	localparam int REG_W   = 9;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;

	// Edge directions: axis steps below DIAG_BASE, diagonals up to NUM_DIRS - 1
	localparam logic [DIR_W-1:0] DIAG_BASE = DIR_W'(6);
	localparam logic [DIR_W-1:0] NUM_DIRS  = DIR_W'(14);

	// Register map (word index = paddr[3:2])
	localparam logic [REG_IDX_W-1:0] REG_GRID_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GRID_Z = 2'd2;

	localparam logic [REG_W-1:0] RESET_SIZE = REG_W'(8);

	// Per-item control carried alongside the arithmetic
	typedef struct packed {
		logic [DIR_W-1:0] dir;
		logic             in_main;
		logic             bad;
	} ctl_t;

endpackage

`default_nettype wire

FILE: src/bccni_cfg.sv
// Grid size registers with APB-style access and effective size decode.
`default_nettype none

module bccni_cfg #(
	parameter int MAX_DIM = 256,
	localparam int DW = $clog2(MAX_DIM + 2)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bccni_pkg::PADDR_W-1:0] paddr,
	input  logic [bccni_pkg::PDATA_W-1:0] pwdata,
	output logic [bccni_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output logic [DW-1:0]                 g_x,
	output logic [DW-1:0]                 g_y,
	output logic [DW-1:0]                 g_z,
	output logic [DW-1:0]                 h_x,
	output logic [DW-1:0]                 h_y,
	output logic [DW-1:0]                 h_z
);

	logic [bccni_pkg::REG_W-1:0]     size_x_q;
	logic [bccni_pkg::REG_W-1:0]     size_y_q;
	logic [bccni_pkg::REG_W-1:0]     size_z_q;
	logic [bccni_pkg::REG_W-1:0]     rd_val;
	logic [bccni_pkg::REG_IDX_W-1:0] reg_idx;
	logic                            wr_en;

	// Clamp: zero reads as one, anything above MAX_DIM as MAX_DIM
	function automatic logic [DW-1:0] eff_size(input logic [bccni_pkg::REG_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DW'(MAX_DIM);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	assign pready  = 1'b1;
	assign reg_idx = paddr[bccni_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= bccni_pkg::RESET_SIZE;
			size_y_q <= bccni_pkg::RESET_SIZE;
			size_z_q <= bccni_pkg::RESET_SIZE;
		end else if (wr_en) begin
			case (reg_idx)
				bccni_pkg::REG_GRID_X: size_x_q <= pwdata[bccni_pkg::REG_W-1:0];
				bccni_pkg::REG_GRID_Y: size_y_q <= pwdata[bccni_pkg::REG_W-1:0];
				bccni_pkg::REG_GRID_Z: size_z_q <= pwdata[bccni_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bccni_pkg::REG_GRID_X: rd_val = size_x_q;
			bccni_pkg::REG_GRID_Y: rd_val = size_y_q;
			bccni_pkg::REG_GRID_Z: rd_val = size_z_q;
			default:               rd_val = '0;
		endcase
	end

	assign prdata = {{(bccni_pkg::PDATA_W - bccni_pkg::REG_W){1'b0}}, rd_val};

	assign g_x = eff_size(size_x_q);
	assign g_y = eff_size(size_y_q);
	assign g_z = eff_size(size_z_q);
	assign h_x = g_x + DW'(1);
	assign h_y = g_y + DW'(1);
	assign h_z = g_z + DW'(1);

endmodule

`default_nettype wire

FILE: src/bccni_front.sv
// Front pipeline: grid point counts, range check and main/offset grid split.
`default_nettype none

module bccni_front #(
	parameter int MAX_DIM = 256,
	localparam int DW = $clog2(MAX_DIM + 2)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bccni_pkg::IDX_W-1:0] in_index,
	input  logic [bccni_pkg::DIR_W-1:0] in_dir,
	input  logic [DW-1:0]               g_x,
	input  logic [DW-1:0]               g_y,
	input  logic [DW-1:0]               g_z,
	input  logic [DW-1:0]               h_x,
	input  logic [DW-1:0]               h_y,
	input  logic [DW-1:0]               h_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bccni_pkg::IDX_W-1:0] out_index,
	output logic [DW-1:0]               out_dvs,
	output bccni_pkg::ctl_t             out_ctl
);

	localparam int IW    = bccni_pkg::IDX_W;
	localparam int PW    = 2 * DW;
	localparam int CNT_W = 3 * DW + 1;
	localparam int CMP_W = (CNT_W > IW) ? CNT_W : IW;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [IW-1:0]                 idx_s1, idx_s2, idx_s3;
	logic [bccni_pkg::DIR_W-1:0]   dir_s1, dir_s2, dir_s3;
	logic [PW-1:0]                 gxy_s1, hxy_s1;
	logic [CNT_W-1:0]              main_s2, off_s2, total_s3;
	logic                          in_main_s3;
	logic [IW-1:0]                 psub_s3;
	logic [IW-1:0]                 psub_s4;
	logic [DW-1:0]                 dvs_s4;
	bccni_pkg::ctl_t               ctl_s4;

	logic [CMP_W-1:0] idx_ext, main_ext, diff;
	logic             below_main;
	logic             bad;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign idx_ext    = CMP_W'(idx_s2);
	assign main_ext   = CMP_W'(main_s2);
	assign below_main = idx_ext < main_ext;
	assign diff       = idx_ext - main_ext;

	assign bad = (dir_s3 >= bccni_pkg::NUM_DIRS) || (CMP_W'(idx_s3) >= CMP_W'(total_s3));

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			idx_s1 <= in_index;
			dir_s1 <= in_dir;
			gxy_s1 <= PW'(g_x) * PW'(g_y);
			hxy_s1 <= PW'(h_x) * PW'(h_y);
		end
		if (v_s1 && rdy2) begin
			idx_s2  <= idx_s1;
			dir_s2  <= dir_s1;
			main_s2 <= CNT_W'(gxy_s1) * CNT_W'(g_z);
			off_s2  <= CNT_W'(hxy_s1) * CNT_W'(h_z);
		end
		if (v_s2 && rdy3) begin
			idx_s3     <= idx_s2;
			dir_s3     <= dir_s2;
			total_s3   <= main_s2 + off_s2;
			in_main_s3 <= below_main;
			psub_s3    <= below_main ? idx_s2 : diff[IW-1:0];
		end
		if (v_s3 && rdy4) begin
			psub_s4        <= psub_s3;
			dvs_s4         <= in_main_s3 ? g_x : h_x;
			ctl_s4.dir     <= dir_s3;
			ctl_s4.in_main <= in_main_s3;
			ctl_s4.bad     <= bad;
		end
	end

	assign out_valid = v_s4;
	assign out_index = psub_s4;
	assign out_dvs   = dvs_s4;
	assign out_ctl   = ctl_s4;

	a_dvs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_dvs != '0)
		else $error("divisor of zero leaving front pipeline");

endmodule

`default_nettype wire

FILE: src/bccni_div_step.sv
// One restoring division stage: resolve one quotient bit and register it.
`default_nettype none

module bccni_div_step #(
	parameter int DW     = 9,
	parameter int QW     = 26,
	parameter int SIDE_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DW-1:0]     in_rem,
	input  logic [QW-1:0]     in_quo,
	input  logic [DW-1:0]     in_dvs,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DW-1:0]     out_rem,
	output logic [QW-1:0]     out_quo,
	output logic [DW-1:0]     out_dvs,
	output logic [SIDE_W-1:0] out_side
);

	logic [DW:0]       trial;
	logic [DW:0]       diff;
	logic              take;
	logic              valid_s1;
	logic [DW-1:0]     rem_s1;
	logic [QW-1:0]     quo_s1;
	logic [DW-1:0]     dvs_s1;
	logic [SIDE_W-1:0] side_s1;

	// Shift in the next dividend bit; subtract when the divisor fits
	assign trial    = {in_rem, in_quo[QW-1]};
	assign diff     = trial - {1'b0, in_dvs};
	assign take     = trial >= {1'b0, in_dvs};
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_s1  <= take ? diff[DW-1:0] : trial[DW-1:0];
			quo_s1  <= {in_quo[QW-2:0], take};
			dvs_s1  <= in_dvs;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_rem   = rem_s1;
	assign out_quo   = quo_s1;
	assign out_dvs   = dvs_s1;
	assign out_side  = side_s1;

	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rem < out_dvs)
		else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

FILE: src/bccni_back.sv
// Back pipeline: step the coordinates, check the borders, recompose the index.
`default_nettype none

module bccni_back #(
	parameter int MAX_DIM = 256,
	localparam int DW = $clog2(MAX_DIM + 2)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [DW-1:0]               in_cx,
	input  logic [DW-1:0]               in_cy,
	input  logic [DW-1:0]               in_cz,
	input  bccni_pkg::ctl_t             in_ctl,
	input  logic [DW-1:0]               g_x,
	input  logic [DW-1:0]               g_y,
	input  logic [DW-1:0]               g_z,
	input  logic [DW-1:0]               h_x,
	input  logic [DW-1:0]               h_y,
	input  logic [DW-1:0]               h_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bccni_pkg::IDX_W-1:0] out_index,
	output logic                        out_found
);

	localparam int IW    = bccni_pkg::IDX_W;
	localparam int PW    = 2 * DW;
	localparam int CNT_W = 3 * DW + 1;
	localparam int SUM_W = (3 * DW + 2 > IW) ? 3 * DW + 2 : IW;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// Stage 1 comb
	logic                        is_diag;
	logic                        use_h;
	logic [bccni_pkg::DIR_W-1:0] d;
	logic [2:0]                  s;
	logic [2:0]                  inc;
	logic [2:0]                  dec;
	logic [1:0]                  ax;
	logic [DW-1:0]               c_a [3];
	logic [DW-1:0]               lim_a [3];
	logic [DW:0]                 newc [3];
	logic [2:0]                  ok_a;
	logic                        ok;

	logic [DW-1:0]    ncx_s1, ncy_s1, ncz_s1, ncx_s2;
	logic             use_h_s1, use_h_s2;
	logic             ok_s1, ok_s2, ok_s3;
	logic [PW-1:0]    gxy_s1;
	logic [PW-1:0]    t1_s2;
	logic [CNT_W-1:0] main_s2;
	logic [SUM_W-1:0] t2_s3, basepx_s3;
	logic [SUM_W-1:0] sum;
	logic [IW-1:0]    index_s4;
	logic             found_s4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Diagonals cross to the other grid; axis steps stay in their own grid.
	// The offset grid limits and the main count base go together.
	always_comb begin
		is_diag = in_ctl.dir >= bccni_pkg::DIAG_BASE;
		use_h   = is_diag ? in_ctl.in_main : !in_ctl.in_main;
		d       = in_ctl.dir - bccni_pkg::DIAG_BASE;
		s       = {d[0] ^ d[2], d[0] ^ d[1], d[0]};
		ax      = in_ctl.dir[2:1];
		c_a[0]  = in_cx;
		c_a[1]  = in_cy;
		c_a[2]  = in_cz;
		lim_a[0] = use_h ? h_x : g_x;
		lim_a[1] = use_h ? h_y : g_y;
		lim_a[2] = use_h ? h_z : g_z;
		for (int i = 0; i < 3; i++) begin
			if (!is_diag) begin
				inc[i] = (ax == 2'(i)) && in_ctl.dir[0];
				dec[i] = (ax == 2'(i)) && !in_ctl.dir[0];
			end else if (in_ctl.in_main) begin
				inc[i] = s[i];
				dec[i] = 1'b0;
			end else begin
				inc[i] = 1'b0;
				dec[i] = !s[i];
			end
			newc[i] = (DW+1)'(c_a[i]) + (DW+1)'(inc[i]) - (DW+1)'(dec[i]);
			ok_a[i] = !(dec[i] && (c_a[i] == '0)) && (newc[i] < {1'b0, lim_a[i]});
		end
		ok = !in_ctl.bad && (&ok_a);
	end

	assign sum = t2_s3 + basepx_s3;

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			ncx_s1   <= newc[0][DW-1:0];
			ncy_s1   <= newc[1][DW-1:0];
			ncz_s1   <= newc[2][DW-1:0];
			use_h_s1 <= use_h;
			ok_s1    <= ok;
			gxy_s1   <= PW'(g_x) * PW'(g_y);
		end
		if (v_s1 && rdy2) begin
			t1_s2    <= PW'(use_h_s1 ? h_y : g_y) * PW'(ncz_s1) + PW'(ncy_s1);
			main_s2  <= CNT_W'(gxy_s1) * CNT_W'(g_z);
			ncx_s2   <= ncx_s1;
			use_h_s2 <= use_h_s1;
			ok_s2    <= ok_s1;
		end
		if (v_s2 && rdy3) begin
			t2_s3     <= SUM_W'(use_h_s2 ? h_x : g_x) * SUM_W'(t1_s2);
			basepx_s3 <= SUM_W'(use_h_s2 ? main_s2 : '0) + SUM_W'(ncx_s2);
			ok_s3     <= ok_s2;
		end
		if (v_s3 && rdy4) begin
			index_s4 <= ok_s3 ? sum[IW-1:0] : '0;
			found_s4 <= ok_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_index = index_s4;
	assign out_found = found_s4;

	a_step_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ok_s1 |-> (ncx_s1 < (use_h_s1 ? h_x : g_x)) &&
			(ncy_s1 < (use_h_s1 ? h_y : g_y)) && (ncz_s1 < (use_h_s1 ? h_z : g_z)))
		else $error("stepped coordinate outside target grid");

endmodule

`default_nettype wire

FILE: src/bcc_lattice_neighbor_index_core.sv
// Top level of the BCC lattice neighbour index pipeline.
`default_nettype none

// Neighbour lookup in a body-centred-cubic lattice: a main grid of
// grid_size_x * grid_size_y * grid_size_z points (x fastest) followed by an
// offset grid one point larger on each axis. Each transaction on the point
// channel carries a linear point_index and an edge_dir; directions 0..5 step
// one axis (even minus, odd plus) within the same grid, 6..13 step diagonally
// into the other grid. The result transaction returns neighbor_index and
// found; found is low (and neighbor_index zero) when the step leaves the
// lattice, the index lies past the last point, or edge_dir is 14 or 15.
// Throughput is one transaction per clock when nothing stalls.
// The pipeline is built from two restoring dividers (index by x size, then
// by y size), each resolving one quotient bit per pipeline stage, plus four
// stages ahead of them (point counts, range check, grid split) and four
// after them (step and recomposition multiplies). Every stage has its own
// valid bit and ready is chained back stage by stage, so bubbles are
// squeezed out and the input keeps accepting while a result waits.
// Grid sizes sit at byte addresses 0x0, 0x4, 0x8; a size of zero acts as
// one and anything above MAX_DIM acts as MAX_DIM. Write them only while no
// transaction is in flight: the front, hand-over and back read them live.
// There is no memory and no post-reset clearing pass.
module bcc_lattice_neighbor_index_core #(
	parameter int MAX_DIM = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bccni_pkg::PADDR_W-1:0] paddr,
	input  logic [bccni_pkg::PDATA_W-1:0] pwdata,
	output logic [bccni_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	// Query channel
	input  logic                          point_valid,
	output logic                          point_ready,
	input  logic [bccni_pkg::IDX_W-1:0]   point_index,
	input  logic [bccni_pkg::DIR_W-1:0]   edge_dir,
	// Result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [bccni_pkg::IDX_W-1:0]   neighbor_index,
	output logic                          found
);

	localparam int DW     = $clog2(MAX_DIM + 2);
	localparam int IW     = bccni_pkg::IDX_W;
	localparam int CTL_W  = $bits(bccni_pkg::ctl_t);
	localparam int SIDE2_W = CTL_W + DW;

	// Effective grid sizes, main (g) and offset (h)
	logic [DW-1:0] g_x, g_y, g_z, h_x, h_y, h_z;

	// Front pipeline outputs
	logic                fr_valid, fr_ready;
	logic [IW-1:0]       fr_index;
	logic [DW-1:0]       fr_dvs;
	bccni_pkg::ctl_t     fr_ctl;

	// First divider chain: index / x size -> x coordinate and remainder quotient
	logic                d1_valid [IW+1];
	logic                d1_ready [IW+1];
	logic [DW-1:0]       d1_rem   [IW+1];
	logic [IW-1:0]       d1_quo   [IW+1];
	logic [DW-1:0]       d1_dvs   [IW+1];
	logic [CTL_W-1:0]    d1_side  [IW+1];

	// Second divider chain: quotient / y size -> y and z coordinates
	logic                d2_valid [IW+1];
	logic                d2_ready [IW+1];
	logic [DW-1:0]       d2_rem   [IW+1];
	logic [IW-1:0]       d2_quo   [IW+1];
	logic [DW-1:0]       d2_dvs   [IW+1];
	logic [SIDE2_W-1:0]  d2_side  [IW+1];

	bccni_pkg::ctl_t     mid_ctl;
	bccni_pkg::ctl_t     bk_ctl;

	bccni_cfg #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.g_x     (g_x),
		.g_y     (g_y),
		.g_z     (g_z),
		.h_x     (h_x),
		.h_y     (h_y),
		.h_z     (h_z)
	);

	// Counts, range check, and rebase of offset-grid indices
	bccni_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point_valid),
		.in_ready  (point_ready),
		.in_index  (point_index),
		.in_dir    (edge_dir),
		.g_x       (g_x),
		.g_y       (g_y),
		.g_z       (g_z),
		.h_x       (h_x),
		.h_y       (h_y),
		.h_z       (h_z),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_index (fr_index),
		.out_dvs   (fr_dvs),
		.out_ctl   (fr_ctl)
	);

	// Seed the first divider with a zero remainder
	assign d1_valid[0] = fr_valid;
	assign fr_ready    = d1_ready[0];
	assign d1_rem[0]   = '0;
	assign d1_quo[0]   = fr_index;
	assign d1_dvs[0]   = fr_dvs;
	assign d1_side[0]  = fr_ctl;

	for (genvar k = 0; k < IW; k++) begin : g_div_x
		bccni_div_step #(
			.DW     (DW),
			.QW     (IW),
			.SIDE_W (CTL_W)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (d1_valid[k]),
			.in_ready  (d1_ready[k]),
			.in_rem    (d1_rem[k]),
			.in_quo    (d1_quo[k]),
			.in_dvs    (d1_dvs[k]),
			.in_side   (d1_side[k]),
			.out_valid (d1_valid[k+1]),
			.out_ready (d1_ready[k+1]),
			.out_rem   (d1_rem[k+1]),
			.out_quo   (d1_quo[k+1]),
			.out_dvs   (d1_dvs[k+1]),
			.out_side  (d1_side[k+1])
		);
	end

	// Hand over: the x remainder rides along as side data; divide by y size
	assign mid_ctl     = bccni_pkg::ctl_t'(d1_side[IW]);
	assign d2_valid[0] = d1_valid[IW];
	assign d1_ready[IW] = d2_ready[0];
	assign d2_rem[0]   = '0;
	assign d2_quo[0]   = d1_quo[IW];
	assign d2_dvs[0]   = mid_ctl.in_main ? g_y : h_y;
	assign d2_side[0]  = {d1_side[IW], d1_rem[IW]};

	for (genvar k = 0; k < IW; k++) begin : g_div_y
		bccni_div_step #(
			.DW     (DW),
			.QW     (IW),
			.SIDE_W (SIDE2_W)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (d2_valid[k]),
			.in_ready  (d2_ready[k]),
			.in_rem    (d2_rem[k]),
			.in_quo    (d2_quo[k]),
			.in_dvs    (d2_dvs[k]),
			.in_side   (d2_side[k]),
			.out_valid (d2_valid[k+1]),
			.out_ready (d2_ready[k+1]),
			.out_rem   (d2_rem[k+1]),
			.out_quo   (d2_quo[k+1]),
			.out_dvs   (d2_dvs[k+1]),
			.out_side  (d2_side[k+1])
		);
	end

	// z is the final quotient; it fits DW bits whenever the index was in range
	assign bk_ctl = bccni_pkg::ctl_t'(d2_side[IW][DW +: CTL_W]);

	bccni_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d2_valid[IW]),
		.in_ready  (d2_ready[IW]),
		.in_cx     (d2_side[IW][DW-1:0]),
		.in_cy     (d2_rem[IW]),
		.in_cz     (d2_quo[IW][DW-1:0]),
		.in_ctl    (bk_ctl),
		.g_x       (g_x),
		.g_y       (g_y),
		.g_z       (g_z),
		.h_x       (h_x),
		.h_y       (h_y),
		.h_z       (h_z),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_index (neighbor_index),
		.out_found (found)
	);

	a_miss_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> neighbor_index == '0)
		else $error("missing neighbour reported with non-zero index");

	a_z_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		d2_valid[IW] && !bk_ctl.bad |->
			d2_quo[IW] < IW'(bk_ctl.in_main ? g_z : h_z))
		else $error("z coordinate of an in-range query outside its grid");

endmodule

`default_nettype wire

FILE: dv/bccni_neighbor_checker.sv
// Scoreboard for the BCC neighbour index block: predicts every lookup and checks each result.
module bccni_neighbor_checker #(
	parameter int MAX_DIM = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bccni_pkg::PADDR_W-1:0] paddr,
	input  logic [bccni_pkg::PDATA_W-1:0] pwdata,
	input  logic [bccni_pkg::PDATA_W-1:0] prdata,
	input  logic                          pready,
	input  logic                          point_valid,
	input  logic                          point_ready,
	input  logic [bccni_pkg::IDX_W-1:0]   point_index,
	input  logic [bccni_pkg::DIR_W-1:0]   edge_dir,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic [bccni_pkg::IDX_W-1:0]   neighbor_index,
	input  logic                          found,
	output int                            neighbors_due,
	output int                            mismatches
);

	typedef struct packed {
		logic [bccni_pkg::IDX_W-1:0] index;
		logic                        hit;
	} lookup_t;

	logic [bccni_pkg::REG_W-1:0] grid_size [3];
	lookup_t                     expected_neighbors [$];

	initial mismatches = 0;

	task automatic report_mismatch(input string what);
		$display("ERROR %0t: %s", $time, what);
		mismatches++;
	endtask

	// Zero acts as one, anything above MAX_DIM as MAX_DIM
	function automatic longint live_size(input logic [bccni_pkg::REG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return longint'(v);
	endfunction

	function automatic lookup_t predict_neighbor(input logic [bccni_pkg::IDX_W-1:0] idx,
			input logic [bccni_pkg::DIR_W-1:0] dir);
		longint  g [3];
		longint  h [3];
		longint  c [3];
		longint  lim [3];
		longint  p, main_n, total_n, base;
		logic    in_main, ok;
		logic [2:0] d, s;
		int      ax, i;
		lookup_t res;
		res = '0;
		for (i = 0; i < 3; i++) begin
			g[i] = live_size(grid_size[i]);
			h[i] = g[i] + 1;
		end
		main_n  = g[0] * g[1] * g[2];
		total_n = main_n + h[0] * h[1] * h[2];
		p = longint'(idx);
		if (dir >= bccni_pkg::NUM_DIRS || p >= total_n)
			return res;
		in_main = (p < main_n);
		if (!in_main)
			p = p - main_n;
		for (i = 0; i < 3; i++) begin
			lim[i] = in_main ? g[i] : h[i];
			c[i]   = p % lim[i];
			p      = p / lim[i];
		end
		ok = 1'b1;
		if (dir < bccni_pkg::DIAG_BASE) begin
			// axis step: stays in its own grid
			ax = int'(dir >> 1);
			if (dir[0])
				c[ax] = c[ax] + 1;
			else
				c[ax] = c[ax] - 1;
			if (c[ax] < 0 || c[ax] >= lim[ax])
				ok = 1'b0;
			base = in_main ? 0 : main_n;
		end else begin
			// diagonal: hop to the other grid
			d = 3'(dir - bccni_pkg::DIAG_BASE);
			s = {d[0] ^ d[2], d[0] ^ d[1], d[0]};
			for (i = 0; i < 3; i++) begin
				if (in_main) begin
					c[i]   = c[i] + longint'(s[i]);
					lim[i] = h[i];
				end else begin
					c[i]   = c[i] + longint'(s[i]) - 1;
					lim[i] = g[i];
				end
				if (c[i] < 0 || c[i] >= lim[i])
					ok = 1'b0;
			end
			base = in_main ? main_n : 0;
		end
		if (!ok)
			return res;
		res.index = bccni_pkg::IDX_W'(base + c[0] + lim[0] * (c[1] + lim[1] * c[2]));
		res.hit   = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		logic [bccni_pkg::PDATA_W-1:0] reg_word;
		if (!arst_n) begin
			grid_size[bccni_pkg::REG_GRID_X] <= bccni_pkg::RESET_SIZE;
			grid_size[bccni_pkg::REG_GRID_Y] <= bccni_pkg::RESET_SIZE;
			grid_size[bccni_pkg::REG_GRID_Z] <= bccni_pkg::RESET_SIZE;
			expected_neighbors.delete();
			neighbors_due <= 0;
		end else begin
			if (psel && penable && pready && paddr[3:2] <= bccni_pkg::REG_GRID_Z) begin
				if (pwrite) begin
					grid_size[paddr[3:2]] <= pwdata[bccni_pkg::REG_W-1:0];
				end else begin
					reg_word = bccni_pkg::PDATA_W'(grid_size[paddr[3:2]]);
					if (prdata !== reg_word)
						report_mismatch($sformatf("register %0d read 0x%0h, want 0x%0h",
							paddr[3:2], prdata, reg_word));
				end
			end
			if (point_valid && point_ready)
				expected_neighbors.insert(expected_neighbors.size(),
					predict_neighbor(point_index, edge_dir));
			if (result_valid && result_ready) begin
				if (expected_neighbors.size() == 0) begin
					report_mismatch("result transaction with no lookup outstanding");
				end else begin
					want = expected_neighbors.pop_front();
					if (neighbor_index !== want.index)
						report_mismatch($sformatf("neighbor_index %0d, want %0d",
							neighbor_index, want.index));
					if (found !== want.hit)
						report_mismatch($sformatf("found %b, want %b", found, want.hit));
				end
			end
			neighbors_due <= expected_neighbors.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// Top of the BCC neighbour index testbench: clock, reset, stimulus and verdict.
module testbench;

	localparam int MAX_DIM       = 256;
	localparam int PHASE_ITEMS   = 148;
	localparam int PACE_SPAN     = 37;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 200000;

	// Edge directions used by name in the directed part
	localparam logic [bccni_pkg::DIR_W-1:0] DIR_X_MINUS   = bccni_pkg::DIR_W'(0);
	localparam logic [bccni_pkg::DIR_W-1:0] DIR_X_PLUS    = bccni_pkg::DIR_W'(1);
	localparam logic [bccni_pkg::DIR_W-1:0] DIR_Z_MINUS   = bccni_pkg::DIR_W'(4);
	localparam logic [bccni_pkg::DIR_W-1:0] DIR_Z_PLUS    = bccni_pkg::DIR_W'(5);
	localparam logic [bccni_pkg::DIR_W-1:0] DIR_DIAG_LAST =
		bccni_pkg::NUM_DIRS - bccni_pkg::DIR_W'(1);

	typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [bccni_pkg::PADDR_W-1:0]  paddr        = '0;
	logic [bccni_pkg::PDATA_W-1:0]  pwdata       = '0;
	logic [bccni_pkg::PDATA_W-1:0]  prdata;
	logic                           pready;
	logic                           point_valid  = 1'b0;
	logic                           point_ready;
	logic [bccni_pkg::IDX_W-1:0]    point_index  = '0;
	logic [bccni_pkg::DIR_W-1:0]    edge_dir     = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	logic [bccni_pkg::IDX_W-1:0]    neighbor_index;
	logic                           found;

	int neighbors_due;
	int mismatches;
	int gap_pct      = 0;
	int stall_pct    = 0;
	int queries_sent = 0;
	int cycle_count  = 0;

	// Sizes last written, used only to aim the random indices
	logic [bccni_pkg::REG_W-1:0] size_cfg [3] =
		'{bccni_pkg::RESET_SIZE, bccni_pkg::RESET_SIZE, bccni_pkg::RESET_SIZE};

	bcc_lattice_neighbor_index_core #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.point_valid, .point_ready, .point_index, .edge_dir,
		.result_valid, .result_ready, .neighbor_index, .found
	);

	bccni_neighbor_checker #(
		.MAX_DIM(MAX_DIM)
	) i_checker (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.point_valid, .point_ready, .point_index, .edge_dir,
		.result_valid, .result_ready, .neighbor_index, .found,
		.neighbors_due, .mismatches
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stall the result side at the rate of the current pacing phase
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= stall_pct);

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FREE: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			PACE_SENDER: begin
				gap_pct = 52;
				stall_pct = 0;
			end
			PACE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 52;
			end
			default: begin
				gap_pct = 6;
				stall_pct = 6;
			end
		endcase
	endtask

	// One APB transfer: setup cycle, then access cycle held until pready
	task automatic apb_access(input logic is_write,
			input logic [bccni_pkg::REG_IDX_W-1:0] reg_idx,
			input logic [bccni_pkg::REG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {reg_idx, 2'b00};
		// junk in the upper bits: only the low REG_W bits must stick
		pwdata  <= bccni_pkg::PDATA_W'({$urandom, value}) & {bccni_pkg::PDATA_W{is_write}};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_grid();
		apb_access(1'b0, bccni_pkg::REG_GRID_X, '0);
		apb_access(1'b0, bccni_pkg::REG_GRID_Y, '0);
		apb_access(1'b0, bccni_pkg::REG_GRID_Z, '0);
	endtask

	task automatic set_grid(input logic [bccni_pkg::REG_W-1:0] sx,
			input logic [bccni_pkg::REG_W-1:0] sy,
			input logic [bccni_pkg::REG_W-1:0] sz);
		size_cfg[bccni_pkg::REG_GRID_X] = sx;
		size_cfg[bccni_pkg::REG_GRID_Y] = sy;
		size_cfg[bccni_pkg::REG_GRID_Z] = sz;
		apb_access(1'b1, bccni_pkg::REG_GRID_X, sx);
		apb_access(1'b1, bccni_pkg::REG_GRID_Y, sy);
		apb_access(1'b1, bccni_pkg::REG_GRID_Z, sz);
		read_grid();
	endtask

	// Present one query and hold it until the transaction is taken
	task automatic send_query(input logic [bccni_pkg::IDX_W-1:0] idx,
			input logic [bccni_pkg::DIR_W-1:0] dir);
		set_pace(pace_t'((queries_sent / PACE_SPAN) % 4));
		queries_sent++;
		while ($urandom_range(99) < gap_pct) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point_index <= idx;
		edge_dir    <= dir;
		@(posedge clk);
		while (!point_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		point_valid <= 1'b0;
		do
			@(posedge clk);
		while (neighbors_due != 0);
	endtask

	function automatic longint main_span(input logic [bccni_pkg::REG_W-1:0] v);
		if (v == '0)
			return 1;
		return (v > MAX_DIM) ? MAX_DIM : longint'(v);
	endfunction

	// Mostly well-formed lookups with coordinates pulled towards the borders,
	// plus indices just past the lattice, raw 26-bit noise and directions 14 and 15
	task automatic random_query();
		longint dim [3];
		longint coord [3];
		longint main_n, offset_n, idx;
		logic   in_offset;
		int     pick, i;
		logic [bccni_pkg::DIR_W-1:0] dir;
		pick = $urandom_range(99);
		in_offset = (pick >= 55);
		for (i = 0; i < 3; i++)
			dim[i] = main_span(size_cfg[i]);
		main_n   = dim[0] * dim[1] * dim[2];
		offset_n = (dim[0] + 1) * (dim[1] + 1) * (dim[2] + 1);
		for (i = 0; i < 3; i++) begin
			dim[i] = dim[i] + (in_offset ? 1 : 0);
			case ($urandom_range(3))
				0: coord[i] = 0;
				1: coord[i] = dim[i] - 1;
				default: coord[i] = $urandom_range(int'(dim[i]) - 1, 0);
			endcase
		end
		idx = (in_offset ? main_n : 0) + coord[0] + dim[0] * (coord[1] + dim[1] * coord[2]);
		if (pick < 5)
			idx = longint'($urandom);
		else if (pick < 10)
			idx = main_n + offset_n + $urandom_range(2);
		if ($urandom_range(99) < 6)
			dir = bccni_pkg::DIR_W'($urandom_range(15, 14));
		else
			dir = bccni_pkg::DIR_W'($urandom_range(13, 0));
		send_query(bccni_pkg::IDX_W'(idx), dir);
	endtask

	task automatic run_phase();
		int n;
		for (n = 0; n < PHASE_ITEMS; n++)
			random_query();
		drain();
	endtask

	initial begin
		int k;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes of 8: 512 main points, 729 offset points
		read_grid();
		for (k = 0; k < 16; k++)
			send_query('0, bccni_pkg::DIR_W'(k));              // origin, every direction
		send_query(bccni_pkg::IDX_W'(511), DIR_X_PLUS);       // last main point, off x border
		send_query(bccni_pkg::IDX_W'(511), DIR_DIAG_LAST);    // main corner into offset grid
		send_query(bccni_pkg::IDX_W'(512), bccni_pkg::DIAG_BASE); // offset origin, below main
		send_query(bccni_pkg::IDX_W'(1240), bccni_pkg::DIAG_BASE); // far corner, lands inside
		send_query(bccni_pkg::IDX_W'(1240), DIR_DIAG_LAST);   // far corner, lands outside
		send_query(bccni_pkg::IDX_W'(1240), DIR_Z_PLUS);      // last point, off the z border
		send_query(bccni_pkg::IDX_W'(1241), DIR_X_MINUS);     // first index past the lattice
		send_query('1, DIR_Z_MINUS);                          // all index bits set
		run_phase();

		set_grid(bccni_pkg::REG_W'(1), bccni_pkg::REG_W'(1), bccni_pkg::REG_W'(1));
		run_phase();
		set_grid(bccni_pkg::REG_W'(256), bccni_pkg::REG_W'(256), bccni_pkg::REG_W'(256));
		run_phase();
		// zero acts as one, oversize saturates
		set_grid(bccni_pkg::REG_W'(0), bccni_pkg::REG_W'(511), bccni_pkg::REG_W'(257));
		run_phase();
		set_grid(bccni_pkg::REG_W'(1), bccni_pkg::REG_W'(256), bccni_pkg::REG_W'(2));
		run_phase();
		set_grid(bccni_pkg::REG_W'(5), bccni_pkg::REG_W'(3), bccni_pkg::REG_W'(7));
		run_phase();
		for (k = 0; k < 2; k++) begin
			set_grid(bccni_pkg::REG_W'($urandom_range(12, 1)),
				bccni_pkg::REG_W'($urandom_range(12, 1)),
				bccni_pkg::REG_W'($urandom_range(12, 1)));
			run_phase();
		end
		set_grid(bccni_pkg::REG_W'($urandom_range(511)), bccni_pkg::REG_W'($urandom_range(511)),
			bccni_pkg::REG_W'($urandom_range(511)));
		run_phase();

		// Hold a little past the pipeline depth to catch stray results
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/bccni_pkg.sv
src/bccni_cfg.sv
src/bccni_front.sv
src/bccni_div_step.sv
src/bccni_back.sv
src/bcc_lattice_neighbor_index_core.sv
dv/bccni_neighbor_checker.sv
dv/testbench.sv
